// ===== hw/rtl/gvd_pkg.sv =====
// Shared types, register map, constants and ROM entry function for the gradient pixel block.
package gvd_pkg;

	// configuration port
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_TOP_COLOR    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM_COLOR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TEXTURE_EN   = 3'd4;

	localparam int COLOR_W = 24;
	localparam int DIM_W   = 11;

	localparam logic [COLOR_W-1:0] TOP_COLOR_RST    = 24'hF4E2C3;
	localparam logic [COLOR_W-1:0] BOTTOM_COLOR_RST = 24'hEEDCB9;
	localparam logic [DIM_W-1:0]   AREA_WIDTH_RST   = 11'd240;
	localparam logic [DIM_W-1:0]   AREA_HEIGHT_RST  = 11'd320;

	// pipeline shape
	localparam int T_FRAC     = 16;
	localparam int DIV_STEPS  = 16;
	localparam int COL_STAGES = 5;

	localparam logic [T_FRAC:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};

	// noise hash
	localparam logic [31:0] HASH_X = 32'd73856093;
	localparam logic [31:0] HASH_Y = 32'd19349663;
	localparam logic [31:0] HASH_K = 32'h9E3779B9;

	// 4x4 Bayer matrix, entry {y[1:0], x[1:0]} at nibble [4*i +: 4]
	localparam logic [63:0] BAYER_TAB = 64'h5D7F_91B3_6E4C_A280;

	// travels with the vignette divider
	typedef struct packed {
		logic       w_zero;
		logic [7:0] hash;
		logic [3:0] bay;
	} gvd_side_t;

	// vignette gain for edge distance e (Q15): 1 - 0.12*e^1.8, Q1.16
	function automatic logic [T_FRAC:0] vig_entry(input longint e);
		longint e4;
		longint lo;
		longint hi;
		longint mid;
		longint p;
		int     k;
		e4 = e * e * e * e;
		lo = 0;
		hi = 4096;
		for (k = 0; k < 16; k++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) >>> 1;
				if (mid * mid * mid * mid * mid <= e4)
					lo = mid;
				else
					hi = mid - 1;
			end
		end
		p = (e * lo + 1024) >>> 11;
		return (T_FRAC+1)'(65536 - ((7864 * p + 32768) >>> 16));
	endfunction

endpackage

// ===== hw/rtl/gvd_div.sv =====
// Pipelined restoring divider, a quotient bit per stage 0..Q_W-1, overflow flag, side data.
module gvd_div #(
	parameter int NUM_W  = 26,
	parameter int DEN_W  = 11,
	parameter int Q_W    = 16,
	parameter int STEPS  = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic [STEPS-1:0]  ld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    quo,
	output logic              ovf,
	output logic [SIDE_W-1:0] side_out
);

	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	// stage registers
	logic [W-1:0]      rem_s  [STEPS];
	logic [DEN_W-1:0]  den_s  [STEPS];
	logic [Q_W-1:0]    quo_s  [STEPS];
	logic [STEPS-1:0]  ovf_s;
	logic [SIDE_W-1:0] side_s [STEPS];

	// stage inputs and next values
	logic [W-1:0]      rem_in  [STEPS];
	logic [DEN_W-1:0]  den_in  [STEPS];
	logic [Q_W-1:0]    quo_in  [STEPS];
	logic [STEPS-1:0]  ovf_in;
	logic [SIDE_W-1:0] side_a  [STEPS];
	logic [W-1:0]      rem_nx  [STEPS];
	logic [Q_W-1:0]    quo_nx  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		if (k == 0) begin : g_head
			assign rem_in[k] = W'(num);
			assign den_in[k] = den;
			assign quo_in[k] = '0;
			// quotient does not fit in Q_W bits
			assign ovf_in[k] = W'(num) >= (W'(den) << Q_W);
			assign side_a[k] = side_in;
		end else begin : g_body
			assign rem_in[k] = rem_s[k-1];
			assign den_in[k] = den_s[k-1];
			assign quo_in[k] = quo_s[k-1];
			assign ovf_in[k] = ovf_s[k-1];
			assign side_a[k] = side_s[k-1];
		end

		if (k < Q_W) begin : g_sub
			localparam int B = Q_W - 1 - k;
			logic [W-1:0] dsh;
			logic         take;
			assign dsh       = W'(den_in[k]) << B;
			assign take      = rem_in[k] >= dsh;
			assign rem_nx[k] = take ? rem_in[k] - dsh : rem_in[k];
			assign quo_nx[k] = quo_in[k] | (Q_W'(take) << B);
		end else begin : g_pass
			assign rem_nx[k] = rem_in[k];
			assign quo_nx[k] = quo_in[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STEPS; k++) begin
			if (ld[k]) begin
				rem_s[k]  <= rem_nx[k];
				den_s[k]  <= den_in[k];
				quo_s[k]  <= quo_nx[k];
				ovf_s[k]  <= ovf_in[k];
				side_s[k] <= side_a[k];
			end
		end
	end

	assign quo      = quo_s[STEPS-1];
	assign ovf      = ovf_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

endmodule

// ===== hw/rtl/gvd_color.sv =====
// Color back end: blend, vignette scale, dither and noise, clamp and RGB565 pack.
module gvd_color #(
	parameter int ENTRIES = 256
) (
	input  logic                                clk,
	input  logic [gvd_pkg::COL_STAGES-1:0]      ld,
	input  logic [gvd_pkg::T_FRAC-1:0]          t_quo,
	input  logic                                t_ovf,
	input  logic                                t_zero,
	input  logic [$clog2(ENTRIES)-1:0]          i_quo,
	input  logic                                i_ovf,
	input  gvd_pkg::gvd_side_t                  side,
	input  logic [gvd_pkg::COLOR_W-1:0]         top_color,
	input  logic [gvd_pkg::COLOR_W-1:0]         bottom_color,
	input  logic                                tex,
	output logic [15:0]                         pixel
);

	import gvd_pkg::*;

	localparam int IB = $clog2(ENTRIES);
	localparam int N1 = ENTRIES - 1;

	// constant tables
	logic [T_FRAC:0]    vig_rom [ENTRIES];
	logic signed [9:0]  dith_rb [16];
	logic signed [9:0]  dith_g  [16];
	logic signed [7:0]  nz_rb   [256];
	logic signed [7:0]  nz_g    [256];

	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_rom
		localparam longint E = (longint'(gi) * 65536 + N1) / (2 * N1);
		localparam logic [T_FRAC:0] VE = vig_entry(E);
		assign vig_rom[gi] = VE;
	end

	for (genvar gi = 0; gi < 16; gi++) begin : g_dith
		localparam int BQ  = 2 * int'(BAYER_TAB[4*gi +: 4]) - 15;
		localparam int DRB = (2 * BQ * 973 + 32) >>> 6;
		localparam int DG  = (2 * BQ * 486 + 32) >>> 6;
		assign dith_rb[gi] = 10'(DRB);
		assign dith_g[gi]  = 10'(DG);
	end

	for (genvar gi = 0; gi < 256; gi++) begin : g_noise
		localparam int S   = 2 * gi - 255;
		localparam int NR  = 256 * S + 425;
		localparam int NG  = 768 * S + 2125;
		localparam int QRB = (NR >= 0) ? NR / 850 : -((849 - NR) / 850);
		localparam int QG  = (NG >= 0) ? NG / 4250 : -((4249 - NG) / 4250);
		assign nz_rb[gi] = 8'(QRB);
		assign nz_g[gi]  = 8'(QG);
	end

	// stage 1: resolve blend factor and vignette index
	logic [T_FRAC:0] t_s1;
	logic [IB-1:0]   idx_s1;
	logic [7:0]      hash_s1;
	logic [3:0]      bay_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			if (t_zero)
				t_s1 <= '0;
			else if (t_ovf)
				t_s1 <= T_ONE;
			else
				t_s1 <= {1'b0, t_quo};
			if (side.w_zero)
				idx_s1 <= '0;
			else if (i_ovf || i_quo > IB'(N1))
				idx_s1 <= IB'(N1);
			else
				idx_s1 <= i_quo;
			hash_s1 <= side.hash;
			bay_s1  <= side.bay;
		end
	end

	// stage 2: ROM read, (bot - top) * t, dither plus noise
	logic signed [8:0]  diff [3];
	logic signed [17:0] t_sg;
	logic [T_FRAC:0]    v_s2;
	logic signed [26:0] prod_s2 [3];
	logic signed [10:0] dn_rb_s2;
	logic signed [10:0] dn_g_s2;

	always_comb begin
		t_sg = $signed({1'b0, t_s1});
		for (int c = 0; c < 3; c++) begin
			diff[c] = $signed({1'b0, bottom_color[8*c +: 8]}) - $signed({1'b0, top_color[8*c +: 8]});
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			v_s2 <= vig_rom[idx_s1];
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= diff[c] * t_sg;
			end
			dn_rb_s2 <= 11'(dith_rb[bay_s1]) + 11'(nz_rb[hash_s1]);
			dn_g_s2  <= 11'(dith_g[bay_s1]) + 11'(nz_g[hash_s1]);
		end
	end

	// stage 3: Q8.8 base = top*256 + floor(prod / 256)
	logic signed [26:0] base_full [3];
	logic [15:0]        base_s3 [3];
	logic [T_FRAC:0]    v_s3;
	logic signed [10:0] dn_rb_s3;
	logic signed [10:0] dn_g_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			base_full[c] = $signed({11'b0, top_color[8*c +: 8], 8'b0}) + (prod_s2[c] >>> 8);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int c = 0; c < 3; c++) begin
				base_s3[c] <= base_full[c][15:0];
			end
			v_s3     <= v_s2;
			dn_rb_s3 <= dn_rb_s2;
			dn_g_s3  <= dn_g_s2;
		end
	end

	// stage 4: vignette scale
	logic [32:0]        mv [3];
	logic [15:0]        scl_s4 [3];
	logic signed [10:0] dn_rb_s4;
	logic signed [10:0] dn_g_s4;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mv[c] = 33'(base_s3[c]) * 33'(v_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			for (int c = 0; c < 3; c++) begin
				scl_s4[c] <= mv[c][31:16];
			end
			dn_rb_s4 <= dn_rb_s3;
			dn_g_s4  <= dn_g_s3;
		end
	end

	// stage 5: texture, clamp, pack
	logic signed [10:0] dn_c [3];
	logic signed [17:0] sum [3];
	logic [7:0]         chv [3];
	logic [15:0]        pixel_s5;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dn_c[c] = (c == 1) ? dn_g_s4 : dn_rb_s4;
			sum[c]  = $signed({2'b0, scl_s4[c]}) + (tex ? 18'(dn_c[c]) : 18'sd0);
			if (sum[c][17])
				chv[c] = 8'h00;
			else if (sum[c][16])
				chv[c] = 8'hFF;
			else
				chv[c] = sum[c][15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			pixel_s5 <= {chv[2][7:3], chv[1][7:2], chv[0][7:3]};
		end
	end

	assign pixel = pixel_s5;

endmodule

// ===== hw/rtl/gradient_vignette_dither_pixel.sv =====
// Top level: vertical gradient background pixel with vignette and ordered dither.
//
// Channel | Role    | Handshake            | Payload
// --------+---------+----------------------+---------------------------------
// cfg     | slave   | psel/penable/pready  | paddr, pwdata, prdata (APB-style)
// pos     | sink    | pos_valid/pos_stall  | pos_x, pos_y
// pixel   | source  | pixel_valid/stall    | pixel (RGB565)
//
// One request per clock unless a stall on pixel backs up the full pipe; the longest part of
// the pipe is the 16-stage restoring divider that forms the Q1.16 row blend factor.
// The vignette index divider runs alongside it in the same stages.
// Reset clears all stage valid bits and loads the register defaults.
// A stall on pixel only holds stages that are full: bubbles close up, so
// pos_stall rises only when every stage holds a request.
module gradient_vignette_dither_pixel #(
	parameter int COORD_BITS       = 10,
	parameter int VIGNETTE_ENTRIES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gvd_pkg::ADDR_W-1:0]    paddr,
	input  logic [gvd_pkg::DATA_W-1:0]    pwdata,
	output logic [gvd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,

	input  logic                          pos_valid,
	output logic                          pos_stall,
	input  logic [COORD_BITS-1:0]         pos_x,
	input  logic [COORD_BITS-1:0]         pos_y,

	output logic                          pixel_valid,
	input  logic                          pixel_stall,
	output logic [15:0]                   pixel
);

	import gvd_pkg::*;

	localparam int IB   = $clog2(VIGNETTE_ENTRIES);
	localparam int N1   = VIGNETTE_ENTRIES - 1;
	// |2x - (w-1)| needs room for both 2x and w-1
	localparam int AN_W = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
	localparam int NI_W = AN_W + IB + 2;
	localparam int TN_W = COORD_BITS + T_FRAC;
	localparam int NS   = 1 + DIV_STEPS + COL_STAGES;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [COLOR_W-1:0] top_color_q;
	logic [COLOR_W-1:0] bottom_color_q;
	logic [DIM_W-1:0]   area_width_q;
	logic [DIM_W-1:0]   area_height_q;
	logic               texture_en_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_color_q    <= TOP_COLOR_RST;
			bottom_color_q <= BOTTOM_COLOR_RST;
			area_width_q   <= AREA_WIDTH_RST;
			area_height_q  <= AREA_HEIGHT_RST;
			texture_en_q   <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TOP_COLOR:    top_color_q    <= pwdata[COLOR_W-1:0];
				REG_BOTTOM_COLOR: bottom_color_q <= pwdata[COLOR_W-1:0];
				REG_AREA_WIDTH:   area_width_q   <= pwdata[DIM_W-1:0];
				REG_AREA_HEIGHT:  area_height_q  <= pwdata[DIM_W-1:0];
				REG_TEXTURE_EN:   texture_en_q   <= pwdata[0];
				default: ; // unmapped, write dropped
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOP_COLOR:    prdata = DATA_W'(top_color_q);
			REG_BOTTOM_COLOR: prdata = DATA_W'(bottom_color_q);
			REG_AREA_WIDTH:   prdata = DATA_W'(area_width_q);
			REG_AREA_HEIGHT:  prdata = DATA_W'(area_height_q);
			REG_TEXTURE_EN:   prdata = DATA_W'(texture_en_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Stage valids and per-stage load enables
	// A stage loads unless pixel stalls and it and every stage below it are full.
	// ---------------------------------------------------------------
	logic [NS-1:0] stg_vld_q;
	logic [NS-1:0] ld;

	for (genvar k = 0; k < NS; k++) begin : g_ld
		assign ld[k] = !pixel_stall || !(&stg_vld_q[NS-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (ld[0])
				stg_vld_q[0] <= pos_valid;
			for (int k = 1; k < NS; k++) begin
				if (ld[k])
					stg_vld_q[k] <= stg_vld_q[k-1];
			end
		end
	end

	assign pos_stall   = !ld[0];
	assign pixel_valid = stg_vld_q[NS-1];

	// ---------------------------------------------------------------
	// Stage 1: set up both divisions and the noise hash
	//   t   = floor(y * 2^16 / (h-1))
	//   idx = floor((2*|2x-(w-1)|*N1 + (w-1)) / (2*(w-1)))
	// ---------------------------------------------------------------
	logic [DIM_W-1:0]       h_m1;
	logic [DIM_W-1:0]       w_m1;
	logic signed [AN_W:0]   i_diff;
	logic [AN_W-1:0]        i_abs;
	logic [31:0]            h2;
	gvd_side_t              side_nx;

	always_comb begin
		h_m1   = area_height_q - DIM_W'(1);
		w_m1   = area_width_q - DIM_W'(1);
		i_diff = $signed((AN_W+1)'({pos_x, 1'b0})) - $signed((AN_W+1)'(w_m1));
		i_abs  = i_diff[AN_W] ? AN_W'(-i_diff) : AN_W'(i_diff);
		h2     = (32'(pos_x) * HASH_X) ^ (32'(pos_y) * HASH_Y) ^ HASH_K;
		side_nx.w_zero = area_width_q <= DIM_W'(1);
		side_nx.hash   = h2[15:8];
		side_nx.bay    = {pos_y[1:0], pos_x[1:0]};
	end

	logic [TN_W-1:0]  t_num_s1;
	logic [DIM_W-1:0] t_den_s1;
	logic             t_zero_s1;
	logic [NI_W-1:0]  i_num_s1;
	logic [DIM_W:0]   i_den_s1;
	gvd_side_t        side_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			t_num_s1  <= {pos_y, {T_FRAC{1'b0}}};
			t_den_s1  <= h_m1;
			t_zero_s1 <= area_height_q <= DIM_W'(1);
			i_num_s1  <= NI_W'(i_abs) * NI_W'(2 * N1) + NI_W'(w_m1);
			i_den_s1  <= {w_m1, 1'b0};
			side_s1   <= side_nx;
		end
	end

	// ---------------------------------------------------------------
	// Stages 2..17: two dividers in lockstep
	// ---------------------------------------------------------------
	logic [T_FRAC-1:0]        t_quo;
	logic                     t_ovf;
	logic                     t_zero_d;
	logic [IB-1:0]            i_quo;
	logic                     i_ovf;
	logic [$bits(gvd_side_t)-1:0] side_d;

	gvd_div #(
		.NUM_W  (TN_W),
		.DEN_W  (DIM_W),
		.Q_W    (T_FRAC),
		.STEPS  (DIV_STEPS),
		.SIDE_W (1)
	) u_tdiv (
		.clk      (clk),
		.ld       (ld[DIV_STEPS:1]),
		.num      (t_num_s1),
		.den      (t_den_s1),
		.side_in  (t_zero_s1),
		.quo      (t_quo),
		.ovf      (t_ovf),
		.side_out (t_zero_d)
	);

	gvd_div #(
		.NUM_W  (NI_W),
		.DEN_W  (DIM_W + 1),
		.Q_W    (IB),
		.STEPS  (DIV_STEPS),
		.SIDE_W ($bits(gvd_side_t))
	) u_idiv (
		.clk      (clk),
		.ld       (ld[DIV_STEPS:1]),
		.num      (i_num_s1),
		.den      (i_den_s1),
		.side_in  (side_s1),
		.quo      (i_quo),
		.ovf      (i_ovf),
		.side_out (side_d)
	);

	// ---------------------------------------------------------------
	// Stages 18..22: blend, vignette, texture, pack
	// ---------------------------------------------------------------
	gvd_color #(
		.ENTRIES (VIGNETTE_ENTRIES)
	) u_color (
		.clk          (clk),
		.ld           (ld[NS-1:DIV_STEPS+1]),
		.t_quo        (t_quo),
		.t_ovf        (t_ovf),
		.t_zero       (t_zero_d),
		.i_quo        (i_quo),
		.i_ovf        (i_ovf),
		.side         (gvd_side_t'(side_d)),
		.top_color    (top_color_q),
		.bottom_color (bottom_color_q),
		.tex          (texture_en_q),
		.pixel        (pixel)
	);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// input backs up only when the whole pipe is full and the sink stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pos_stall |-> ((&stg_vld_q) && pixel_stall))
		else $error("pos_stall with a free stage");

	// an accepted request lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && !pos_stall) |=> stg_vld_q[0])
		else $error("accepted request lost at stage 1");

	// a taken result is replaced by what the stage above held
	a_shift_out: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> (pixel_valid == $past(stg_vld_q[NS-2])))
		else $error("output stage did not shift");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the gradient/vignette/dither background pixel block.
`timescale 1ns / 1ps

module tb_top;
	import gvd_pkg::*;

	// ---------------------------------------------------------------
	// Block geometry and predictor constants
	// ---------------------------------------------------------------
	localparam int COORD = 10;
	localparam int VIG_N = 256;

	// Bayer 4x4, entry {y[1:0], x[1:0]} in nibble [4*i +: 4]
	localparam logic [63:0] DITHER_4X4 = 64'h5D7F_91B3_6E4C_A280;
	localparam logic [31:0] HASH_MUL_X = 32'd73856093;
	localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
	localparam logic [31:0] HASH_SEED  = 32'h9E3779B9;

	// first index past the register list; writes there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_TEXTURE_EN + 1'b1;

	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int QUIET_LIMIT     = 1000;  // cycles without any handshake
	localparam int TAIL_CYCLES     = 40;    // pipeline is 22 deep

	// directed register setups
	typedef enum int {
		LOOK_RESET,  // power-on registers
		LOOK_WHITE,  // flat white, texture on: clamps high
		LOOK_BLACK,  // flat black, texture on, zero-size area: clamps low
		LOOK_SPLIT,  // white to black over two rows, plain gradient
		LOOK_WIDE    // 1024x1024 area, mixed colors
	} look_e;

	typedef struct packed {
		logic [COORD-1:0] x;
		logic [COORD-1:0] y;
		logic [15:0]      pix;
	} pixel_exp_t;

	typedef struct packed {
		look_e            look;
		logic [COORD-1:0] x;
		logic [COORD-1:0] y;
		bit               known;  // pix typed in by hand, else predicted
		logic [15:0]      pix;
	} probe_t;

	// ---------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ---------------------------------------------------------------
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [ADDR_W-1:0] paddr       = '0;
	logic [DATA_W-1:0] pwdata      = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              pos_valid   = 1'b0;
	logic              pos_stall;
	logic [COORD-1:0]  pos_x       = '0;
	logic [COORD-1:0]  pos_y       = '0;
	logic              pixel_valid;
	logic              pixel_stall = 1'b0;
	logic [15:0]       pixel;

	// travel with the payload so the scoreboard sees them aligned with pos_x/pos_y
	logic        req_known = 1'b0;
	logic [15:0] req_pix   = '0;

	// register mirror used by the predictor
	logic [COLOR_W-1:0] cfg_top;
	logic [COLOR_W-1:0] cfg_bottom;
	logic [DIM_W-1:0]   cfg_w;
	logic [DIM_W-1:0]   cfg_h;
	logic               cfg_tex;

	int unsigned vig_gain [VIG_N];  // Q1.16 vignette gain per index
	pixel_exp_t  pixel_q [$];       // pixels still owed by the block
	probe_t      probes [$];

	int err_cnt    = 0;
	int n_req      = 0;
	int n_checked  = 0;
	int n_settings = 1;  // reset setup counts as one
	int burst_left = 0;
	int quiet_cyc  = 0;
	int stall_mode = 0;
	int stall_hold = 0;
	logic [7:0] stall_tick = '0;

	gradient_vignette_dither_pixel #(
		.COORD_BITS      (COORD),
		.VIGNETTE_ENTRIES(VIG_N)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pos_valid  (pos_valid),
		.pos_stall  (pos_stall),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Pixel predictor
	// ---------------------------------------------------------------
	function automatic longint floor_div(input longint a, input longint d);
		longint q;
		q = a / d;
		if ((a % d != 0) && (a < 0))
			q -= 1;
		return q;
	endfunction

	// a/d rounded half up
	function automatic longint round_div(input longint a, input longint d);
		return floor_div(2 * a + d, 2 * d);
	endfunction

	// 1 - 0.12*e^1.8 in Q1.16; e^0.8 comes from an integer fifth root of e^4
	function automatic int unsigned vignette_gain(input int i);
		longint unsigned e, e4, lo, hi, mid, p;
		e = i;
		e = (e * 65536 + VIG_N - 1) / (2 * (VIG_N - 1));
		e4 = e * e * e * e;
		lo = 0;
		hi = 4096;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * mid * mid * mid <= e4)
				lo = mid;
			else
				hi = mid - 1;
		end
		p = (e * lo + 1024) >> 11;
		return int'(65536 - ((7864 * p + 32768) >> 16));
	endfunction

	// one 8-bit channel: Q8.8 blend, vignette, optional texture, clamp
	function automatic logic [7:0] blend_channel(input longint top, input longint bot,
			input longint t, input longint gain, input longint dith, input longint noise);
		longint base, c;
		base = top * 256 + floor_div((bot - top) * t, 256);
		c = (base * gain) >>> 16;
		if (cfg_tex)
			c += dith + noise;
		if (c < 0)
			c = 0;
		if (c > 65535)
			c = 65535;
		return c[15:8];
	endfunction

	function automatic logic [15:0] predict_pixel(input logic [COORD-1:0] x,
			input logic [COORD-1:0] y);
		longint t, num, an, den, ii, bq, s, nrb, ng, drb, dg;
		int idx;
		logic [31:0] h2;
		logic [7:0] r, g, b;
		t = 0;
		idx = 0;
		// row blend factor, saturates at 1.0 below the area
		if (cfg_h > 1) begin
			t = (longint'(y) * 65536) / (longint'(cfg_h) - 1);
			if (t > 65536)
				t = 65536;
		end
		// distance from the horizontal center, scaled to the ROM range
		if (cfg_w > 1) begin
			num = 2 * longint'(x) - (longint'(cfg_w) - 1);
			an = (num < 0) ? -num : num;
			den = longint'(cfg_w) - 1;
			ii = (2 * an * (VIG_N - 1) + den) / (2 * den);
			idx = (ii > VIG_N - 1) ? VIG_N - 1 : int'(ii);
		end
		bq = 2 * longint'(DITHER_4X4[4 * int'({y[1:0], x[1:0]}) +: 4]) - 15;
		h2 = ({22'd0, x} * HASH_MUL_X) ^ ({22'd0, y} * HASH_MUL_Y) ^ HASH_SEED;
		s = 2 * longint'(h2[15:8]) - 255;
		nrb = round_div(s * 128, 425);
		ng = round_div(s * 384, 2125);
		drb = round_div(bq * 973, 32);
		dg = round_div(bq * 486, 32);
		r = blend_channel(cfg_top[23:16], cfg_bottom[23:16], t, vig_gain[idx], drb, nrb);
		g = blend_channel(cfg_top[15:8], cfg_bottom[15:8], t, vig_gain[idx], dg, ng);
		b = blend_channel(cfg_top[7:0], cfg_bottom[7:0], t, vig_gain[idx], drb, nrb);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// ---------------------------------------------------------------
	// Register port
	// ---------------------------------------------------------------
	// setup, access, then idle with psel low before returning, so back-to-back calls never
	// schedule psel twice in one step
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TOP_COLOR:    cfg_top    = val[COLOR_W-1:0];
			REG_BOTTOM_COLOR: cfg_bottom = val[COLOR_W-1:0];
			REG_AREA_WIDTH:   cfg_w      = val[DIM_W-1:0];
			REG_AREA_HEIGHT:  cfg_h      = val[DIM_W-1:0];
			REG_TEXTURE_EN:   cfg_tex    = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// upper bits are junk on purpose: the block keeps only the register width
	task automatic apply_look(input look_e look);
		case (look)
			LOOK_WHITE: begin
				reg_write(REG_TOP_COLOR,    32'hAB_FF_FF_FF);
				reg_write(REG_BOTTOM_COLOR, 32'h00_FF_FF_FF);
				reg_write(REG_AREA_WIDTH,   32'd1);
				reg_write(REG_AREA_HEIGHT,  32'd1);
				reg_write(REG_TEXTURE_EN,   32'd1);
			end
			LOOK_BLACK: begin
				reg_write(REG_TOP_COLOR,    32'hFF_00_00_00);
				reg_write(REG_BOTTOM_COLOR, 32'h00_00_00_00);
				reg_write(REG_AREA_WIDTH,   32'hFFFF_F800);
				reg_write(REG_AREA_HEIGHT,  32'h0000_0800);
				reg_write(REG_TEXTURE_EN,   32'h0000_0003);
			end
			LOOK_SPLIT: begin
				reg_write(REG_TOP_COLOR,    32'h00_FF_FF_FF);
				reg_write(REG_BOTTOM_COLOR, 32'h00_00_00_00);
				reg_write(REG_AREA_WIDTH,   32'd1);
				reg_write(REG_AREA_HEIGHT,  32'd2);
				reg_write(REG_TEXTURE_EN,   32'hFFFF_FFFE);
				// would turn the bottom row white if it aliased onto a real register
				reg_write(REG_SPARE,        32'hFFFF_FFFF);
			end
			LOOK_WIDE: begin
				reg_write(REG_TOP_COLOR,    32'h00_12_34_56);
				reg_write(REG_BOTTOM_COLOR, 32'h00_FE_DC_BA);
				reg_write(REG_AREA_WIDTH,   32'd1024);
				reg_write(REG_AREA_HEIGHT,  32'd1024);
				reg_write(REG_TEXTURE_EN,   32'd1);
			end
			default: ;
		endcase
		n_settings++;
	endtask

	function automatic logic [23:0] pick_color();
		case ($urandom_range(0, 3))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			default: return 24'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	// zero and one are the degenerate sizes; 2047 is past the nominal range
	function automatic logic [10:0] pick_dim();
		case ($urandom_range(0, 7))
			0:       return 11'd0;
			1:       return 11'd1;
			2:       return 11'd2;
			3:       return 11'd1024;
			4:       return 11'd2047;
			default: return 11'($urandom_range(3, 1024));
		endcase
	endfunction

	// first two phases pin the extremes, the rest are random
	task automatic roll_setting(input int p);
		logic [31:0] top_w, bot_w, w_w, h_w, tex_w;
		top_w = {8'($urandom()), pick_color()};
		bot_w = {8'($urandom()), pick_color()};
		w_w   = ($urandom() & 32'hFFFF_F800) | 32'(pick_dim());
		h_w   = ($urandom() & 32'hFFFF_F800) | 32'(pick_dim());
		tex_w = $urandom();
		if (p == 0) begin
			top_w = 32'h00FF_FFFF;
			bot_w = 32'h0000_0000;
			w_w   = 32'd1024;
			h_w   = 32'd1024;
			tex_w = 32'd1;
		end else if (p == 1) begin
			top_w = 32'h0000_0000;
			bot_w = 32'h00FF_FFFF;
			w_w   = 32'd2;
			h_w   = 32'd2;
			tex_w = 32'd0;
		end
		reg_write(REG_TOP_COLOR,    top_w);
		reg_write(REG_BOTTOM_COLOR, bot_w);
		reg_write(REG_AREA_WIDTH,   w_w);
		reg_write(REG_AREA_HEIGHT,  h_w);
		reg_write(REG_TEXTURE_EN,   tex_w);
		n_settings++;
	endtask

	// mostly uniform, with weight on the area and its borders
	function automatic logic [COORD-1:0] pick_coord(input logic [10:0] span);
		case ($urandom_range(0, 9))
			6, 7:    return (span > 1) ? 10'($urandom_range(0, span - 1)) : 10'd0;
			8:       return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
			9:       return 10'(span - $urandom_range(0, 1));
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Request side: bursts of random length with random gaps
	// ---------------------------------------------------------------
	task automatic push_pos(input logic [COORD-1:0] x, input logic [COORD-1:0] y,
			input bit known, input logic [15:0] pix);
		int gap;
		pos_x     <= x;
		pos_y     <= y;
		req_known <= known;
		req_pix   <= pix;
		pos_valid <= 1'b1;
		do @(posedge clk); while (pos_stall);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 250)
			                                          : $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				pos_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending and let every owed pixel come out; first look comes after
	// the next edge so a request accepted at this edge is already queued
	task automatic wait_pixels_drained();
		pos_valid <= 1'b0;
		do @(posedge clk); while (pixel_q.size() != 0);
	endtask

	task automatic add_probe(input look_e look, input int x, input int y,
			input bit known, input logic [15:0] pix);
		probe_t pr;
		pr.look  = look;
		pr.x     = COORD'(x);
		pr.y     = COORD'(y);
		pr.known = known;
		pr.pix   = pix;
		probes.push_back(pr);
	endtask

	// ---------------------------------------------------------------
	// Result side: stall pattern picks a new random mode when its hold runs out
	//   0 never, 1 light random, 2 heavy random, 3 periodic
	// ---------------------------------------------------------------
	always @(posedge clk) begin : stall_gen
		if (stall_hold == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_hold = $urandom_range(16, 400);
		end else begin
			stall_hold--;
		end
		stall_tick++;
		case (stall_mode)
			0:       pixel_stall <= 1'b0;
			1:       pixel_stall <= ($urandom_range(0, 3) == 0);
			2:       pixel_stall <= ($urandom_range(0, 9) < 7);
			default: pixel_stall <= stall_tick[2];
		endcase
	end

	// ---------------------------------------------------------------
	// Scoreboard: check the result first, then queue the new request,
	// so a request can never satisfy a pixel at its own edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		pixel_exp_t owed;
		if (pixel_valid && !pixel_stall) begin
			if (pixel_q.size() == 0) begin
				err_cnt++;
				$display("%0t: expected no pixel, actual %04h", $time, pixel);
			end else begin
				owed = pixel_q.pop_front();
				n_checked++;
				if (pixel !== owed.pix) begin
					err_cnt++;
					$display("%0t: pixel at (%0d,%0d) expected %04h actual %04h",
						$time, owed.x, owed.y, owed.pix, pixel);
				end
			end
		end
		if (pos_valid && !pos_stall) begin
			owed.x   = pos_x;
			owed.y   = pos_y;
			owed.pix = req_known ? req_pix : predict_pixel(pos_x, pos_y);
			pixel_q.push_back(owed);
			n_req++;
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: any handshake on any port counts as progress
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if ((pos_valid && !pos_stall) || (pixel_valid && !pixel_stall) ||
		    (psel && penable && pready))
			quiet_cyc = 0;
		else
			quiet_cyc++;
		if (quiet_cyc >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d pixels outstanding",
				$time, quiet_cyc, pixel_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		look_e cur;
		int p, k;
		for (int i = 0; i < VIG_N; i++)
			vig_gain[i] = vignette_gain(i);
		cfg_top    = TOP_COLOR_RST;
		cfg_bottom = BOTTOM_COLOR_RST;
		cfg_w      = AREA_WIDTH_RST;
		cfg_h      = AREA_HEIGHT_RST;
		cfg_tex    = 1'b1;

		// power-on setup: corners, center, row and column past the area
		add_probe(LOOK_RESET,    0,    0, 1'b0, 16'h0000);
		add_probe(LOOK_RESET, 1023, 1023, 1'b0, 16'h0000);
		add_probe(LOOK_RESET,  119,    0, 1'b0, 16'h0000);
		add_probe(LOOK_RESET,  120,  319, 1'b0, 16'h0000);
		add_probe(LOOK_RESET,  239,  320, 1'b0, 16'h0000);
		add_probe(LOOK_RESET, 1000,  700, 1'b0, 16'h0000);
		add_probe(LOOK_RESET,    5,    2, 1'b0, 16'h0000);
		add_probe(LOOK_RESET,    2,    7, 1'b0, 16'h0000);
		// flat white: dither and noise must clamp back to full scale
		add_probe(LOOK_WHITE,    0,    0, 1'b1, 16'hFFFF);
		add_probe(LOOK_WHITE, 1023, 1023, 1'b1, 16'hFFFF);
		add_probe(LOOK_WHITE,    3,    3, 1'b1, 16'hFFFF);
		add_probe(LOOK_WHITE,    0,    3, 1'b1, 16'hFFFF);
		// flat black: negative texture clamps to zero, positive is too small to show
		add_probe(LOOK_BLACK,    0,    0, 1'b1, 16'h0000);
		add_probe(LOOK_BLACK,    0,    3, 1'b1, 16'h0000);
		add_probe(LOOK_BLACK, 1023, 1023, 1'b1, 16'h0000);
		// two-row area: top row white, second row and everything below black
		add_probe(LOOK_SPLIT,    7,    0, 1'b1, 16'hFFFF);
		add_probe(LOOK_SPLIT,    7,    1, 1'b1, 16'h0000);
		add_probe(LOOK_SPLIT,  500, 1023, 1'b1, 16'h0000);
		// full-size area
		add_probe(LOOK_WIDE,     0,    0, 1'b0, 16'h0000);
		add_probe(LOOK_WIDE,  1023, 1023, 1'b0, 16'h0000);
		add_probe(LOOK_WIDE,   511,  512, 1'b0, 16'h0000);
		add_probe(LOOK_WIDE,   512,    0, 1'b0, 16'h0000);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = LOOK_RESET;
		foreach (probes[i]) begin
			if (probes[i].look != cur) begin
				wait_pixels_drained();
				apply_look(probes[i].look);
				cur = probes[i].look;
			end
			push_pos(probes[i].x, probes[i].y, probes[i].known, probes[i].pix);
		end

		// random part; each phase also holds off once mid-way until the
		// pipeline is empty
		for (p = 0; p < N_PHASES; p++) begin
			wait_pixels_drained();
			roll_setting(p);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == ITEMS_PER_PHASE / 2)
					wait_pixels_drained();
				push_pos(pick_coord(cfg_w), pick_coord(cfg_h), 1'b0, 16'h0000);
			end
		end

		wait_pixels_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d coordinates under %0d register setups (flat, split, zero-size, random).",
			n_req, n_settings);
		$display("Compared %0d pixels against the predictor and hand values, %0d mismatches.",
			n_checked, err_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/gvd_pkg.sv
hw/rtl/gvd_div.sv
hw/rtl/gvd_color.sv
hw/rtl/gradient_vignette_dither_pixel.sv
verif/tb_top.sv
